// ----- sv/exception_and_timer_interrupt_unit_defines.svh -----
// Assertion macros shared by the exception and timer interrupt unit RTL.
`ifndef EXCEPTION_AND_TIMER_INTERRUPT_UNIT_DEFINES_SVH
`define EXCEPTION_AND_TIMER_INTERRUPT_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property checked on every rising clk_i edge, ignored while rst_ni is low.
`define ETIU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// Condition that must never be seen.
`define ETIU_ASSERT_NEVER(lbl, cond, msg) \
  `ETIU_ASSERT(lbl, !(cond), msg)
`else
`define ETIU_ASSERT(lbl, prop, msg)
`define ETIU_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ----- sv/etiu_pkg.sv -----
// Types and constants of the exception and timer interrupt unit.
`default_nettype none

package etiu_pkg;

  // Operation codes
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_RAISE     = 3'd1;
  localparam logic [2:0] OP_RETURN    = 3'd2;
  localparam logic [2:0] OP_SET_EN    = 3'd3;
  localparam logic [2:0] OP_QUEUE_IRQ = 3'd4;

  // Status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_UNHANDLED   = 3'd1;
  localparam logic [2:0] ST_NESTED      = 3'd2;
  localparam logic [2:0] ST_BAD_VECTOR  = 3'd3;
  localparam logic [2:0] ST_NO_ACTIVE   = 3'd4;
  localparam logic [2:0] ST_MISALIGNED  = 3'd5;
  localparam logic [2:0] ST_NOT_EXEC    = 3'd6;

  // Cause reported for a timer interrupt entry
  localparam logic [3:0] TIMER_CAUSE = 4'd12;

  // Low address bits that must be zero for a valid code address
  localparam logic [1:0] ALIGN_MASK = 2'b11;

  // Configuration register map (index = paddr[4:3])
  localparam int unsigned CFG_ADDR_W = 5;
  localparam logic [1:0] REG_VEC_ADDR     = 2'd0;
  localparam logic [1:0] REG_VECTOR_VALID = 2'd1;
  localparam logic [1:0] REG_TIMER_PERIOD = 2'd2;

  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  cause_code;
    logic [63:0] fault_addr;
    logic [63:0] current_pc;
    logic [63:0] resume_addr;
    logic [63:0] return_target;
    logic [3:0]  cpu_flags;
    logic [63:0] retired_count;
    logic        target_usable;
    logic        enable_value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        entered;
    logic        returned;
    logic [63:0] next_pc;
    logic [3:0]  saved_cause;
    logic [63:0] saved_fault;
    logic [63:0] saved_interrupted;
    logic [63:0] saved_resume;
    logic [3:0]  restored_flags;
    logic        handler_active;
    logic        irq_enabled;
  } out_word_t;

  // Configuration register contents
  typedef struct packed {
    logic [63:0] vec_addr;
    logic        vector_valid;
    logic [63:0] timer_period;
  } cfg_t;

  // Timer period write event for the back end
  typedef struct packed {
    logic period_wr;
    logic period_zero;
  } cfg_wr_t;

  // Decoded operation, one-hot or all zero for unknown codes
  typedef struct packed {
    logic is_tick;
    logic is_raise;
    logic is_return;
    logic is_set_en;
    logic is_queue;
  } kind_t;

  // Classified word passed from front to back
  typedef struct packed {
    kind_t       kind;
    logic [3:0]  cause_code;
    logic [63:0] fault_addr;
    logic [63:0] current_pc;
    logic [63:0] resume_addr;
    logic [63:0] return_target;
    logic [3:0]  cpu_flags;
    logic [63:0] retired_count;
    logic        target_usable;
    logic        enable_value;
    logic        tgt_aligned;
    logic        vec_ok;
    logic        timer_on;
    logic [63:0] rearm_sum;
  } cmd_t;

endpackage

`default_nettype wire

// ----- sv/exception_and_timer_interrupt_unit.sv -----
// Top level: configuration registers, front end, queue and back end.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------
//   in      | input     | in_valid_i / in_stall_o   | in_word_i  (in_word_t)
//   out     | output    | out_valid_o / out_stall_i | out_word_o (out_word_t)
//   cfg     | input     | psel, penable, pwrite     | paddr, pwdata, prdata
//
// One word per cycle sustained while out_stall_i is low; a word's result passes
// through the queue entry, then the back end's output register.
// in_stall_o is high only while the queue is full; the back end stalls on
// out_stall_i alone. Reset clears all unit state and empties the queue;
// no clearing pass is needed.
`default_nettype none

module exception_and_timer_interrupt_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  etiu_pkg::in_word_t                  in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output etiu_pkg::out_word_t                 out_word_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [etiu_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [63:0]                         pwdata,
  output logic [63:0]                         prdata,
  output logic                                pready
);

  etiu_pkg::cfg_t    cfg_q;
  etiu_pkg::cfg_wr_t cfg_wr;
  etiu_pkg::cmd_t    front_cmd, q_cmd;
  logic              cfg_we;
  logic              q_full, q_valid, q_pop, push;

  // Register write strobe
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  assign cfg_wr.period_wr   = cfg_we && (paddr[4:3] == etiu_pkg::REG_TIMER_PERIOD);
  assign cfg_wr.period_zero = pwdata == 64'd0;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we) begin
      unique case (paddr[4:3])
        etiu_pkg::REG_VEC_ADDR:     cfg_q.vec_addr     <= pwdata;
        etiu_pkg::REG_VECTOR_VALID: cfg_q.vector_valid <= pwdata[0];
        etiu_pkg::REG_TIMER_PERIOD: cfg_q.timer_period <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read
  always_comb begin
    unique case (paddr[4:3])
      etiu_pkg::REG_VEC_ADDR:     prdata = cfg_q.vec_addr;
      etiu_pkg::REG_VECTOR_VALID: prdata = {63'd0, cfg_q.vector_valid};
      etiu_pkg::REG_TIMER_PERIOD: prdata = cfg_q.timer_period;
      default:                    prdata = '0;
    endcase
  end

  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  etiu_front u_front (
    .in_word_i (in_word_i),
    .cfg_i     (cfg_q),
    .cmd_o     (front_cmd)
  );

  etiu_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (front_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_word_o  (q_cmd)
  );

  etiu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cfg_wr_i    (cfg_wr),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

// ----- sv/etiu_front.sv -----
// Front end: decodes and pre-checks each input word.
`default_nettype none

module etiu_front (
  input  etiu_pkg::in_word_t in_word_i,
  input  etiu_pkg::cfg_t     cfg_i,
  output etiu_pkg::cmd_t     cmd_o
);

  // Operation decode
  always_comb begin
    cmd_o.kind = '0;
    unique case (in_word_i.operation)
      etiu_pkg::OP_TICK:      cmd_o.kind.is_tick   = 1'b1;
      etiu_pkg::OP_RAISE:     cmd_o.kind.is_raise  = 1'b1;
      etiu_pkg::OP_RETURN:    cmd_o.kind.is_return = 1'b1;
      etiu_pkg::OP_SET_EN:    cmd_o.kind.is_set_en = 1'b1;
      etiu_pkg::OP_QUEUE_IRQ: cmd_o.kind.is_queue  = 1'b1;
      default:                cmd_o.kind = '0;
    endcase
  end

  // Field copy
  assign cmd_o.cause_code    = in_word_i.cause_code;
  assign cmd_o.fault_addr    = in_word_i.fault_addr;
  assign cmd_o.current_pc    = in_word_i.current_pc;
  assign cmd_o.resume_addr   = in_word_i.resume_addr;
  assign cmd_o.return_target = in_word_i.return_target;
  assign cmd_o.cpu_flags     = in_word_i.cpu_flags;
  assign cmd_o.retired_count = in_word_i.retired_count;
  assign cmd_o.target_usable = in_word_i.target_usable;
  assign cmd_o.enable_value  = in_word_i.enable_value;

  // Stateless checks; user keeps config static with words in flight; unenforced
  assign cmd_o.tgt_aligned = (in_word_i.return_target[1:0] & etiu_pkg::ALIGN_MASK) == 2'b00;
  assign cmd_o.vec_ok      = ((cfg_i.vec_addr[1:0] & etiu_pkg::ALIGN_MASK) == 2'b00)
                             && in_word_i.target_usable;
  assign cmd_o.timer_on    = cfg_i.timer_period != 64'd0;

  // Candidate deadline for a re-armed timer
  assign cmd_o.rearm_sum   = in_word_i.retired_count + cfg_i.timer_period;

endmodule

`default_nettype wire

// ----- sv/etiu_fifo.sv -----
// Short queue of classified words between front and back.
`default_nettype none

`include "exception_and_timer_interrupt_unit_defines.svh"

module etiu_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  etiu_pkg::cmd_t push_word_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output etiu_pkg::cmd_t pop_word_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  etiu_pkg::cmd_t  mem_q [Depth];
  logic [IdxW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o     = count_q == CntW'(Depth);
  assign valid_o    = count_q != '0;
  assign pop_word_o = mem_q[rd_ptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == IdxW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == IdxW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `ETIU_ASSERT(a_count_bound, count_q <= CntW'(Depth), "queue count above depth")
  `ETIU_ASSERT(a_count_up, push_i && !pop_i |=> count_q == CntW'($past(count_q) + 1'b1), "queue count missed a push")
  `ETIU_ASSERT_NEVER(a_pop_empty, pop_i && !valid_o, "pop from empty queue")

endmodule

`default_nettype wire

// ----- sv/etiu_back.sv -----
// Back end: unit state, entry and return sequencing, output register.
`default_nettype none

`include "exception_and_timer_interrupt_unit_defines.svh"

module etiu_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  etiu_pkg::cfg_t      cfg_i,
  input  etiu_pkg::cfg_wr_t   cfg_wr_i,
  input  logic                cmd_valid_i,
  input  etiu_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output etiu_pkg::out_word_t out_word_o
);

  // Architectural state; flags, active and enable bits are read back
  logic        active_q, active_d;
  logic        irq_en_q, irq_en_d;
  logic        pending_q, pending_d;
  logic        rearm_q, rearm_d;
  logic [63:0] deadline_q, deadline_d;
  logic [3:0]  ctx_flags_q, ctx_flags_d;

  logic                out_valid_q;
  etiu_pkg::out_word_t out_word_q, res;

  logic        fire;
  logic        tick_upd;
  logic [63:0] nd_base;
  logic        hit;
  logic        ent_req;
  logic [3:0]  ent_cause;
  logic [63:0] ent_fault, ent_ipc, ent_rpc;

  // Execute when a word waits and the output register is free or draining
  assign fire      = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign cmd_pop_o = fire;

  // Deadline terms
  assign tick_upd = cmd_i.kind.is_tick && cmd_i.timer_on && !active_q;
  assign nd_base  = rearm_q ? cmd_i.rearm_sum : deadline_q;
  assign hit      = cmd_i.retired_count >= nd_base;

  always_comb begin
    active_d    = active_q;
    irq_en_d    = irq_en_q;
    pending_d   = pending_q;
    rearm_d     = rearm_q;
    deadline_d  = deadline_q;
    ctx_flags_d = ctx_flags_q;
    res         = '0;
    ent_req     = 1'b0;
    ent_cause   = cmd_i.cause_code;
    ent_fault   = cmd_i.fault_addr;
    ent_ipc     = cmd_i.current_pc;
    ent_rpc     = cmd_i.resume_addr;

    if (fire) begin
      // Tick: deadline update, then timer sample
      if (cmd_i.kind.is_tick) begin
        if (tick_upd) begin
          rearm_d    = 1'b0;
          deadline_d = nd_base;
          if (hit) begin
            pending_d  = 1'b1;
            deadline_d = nd_base + cfg_i.timer_period;
          end
        end
        if (irq_en_q && !active_q && (pending_q || (tick_upd && hit))) begin
          pending_d = 1'b0;
          ent_req   = 1'b1;
          ent_cause = etiu_pkg::TIMER_CAUSE;
          ent_fault = '0;
          ent_rpc   = cmd_i.current_pc;
        end
      end

      if (cmd_i.kind.is_raise) begin
        ent_req = 1'b1;
      end

      // Entry checks in order
      if (ent_req) begin
        if (!cfg_i.vector_valid) begin
          res.status = etiu_pkg::ST_UNHANDLED;
        end else if (active_q) begin
          res.status = etiu_pkg::ST_NESTED;
        end else if (!cmd_i.vec_ok) begin
          res.status = etiu_pkg::ST_BAD_VECTOR;
        end else begin
          active_d              = 1'b1;
          irq_en_d              = 1'b0;
          ctx_flags_d           = cmd_i.cpu_flags;
          res.entered           = 1'b1;
          res.next_pc           = cfg_i.vec_addr;
          res.saved_cause       = ent_cause;
          res.saved_fault       = ent_fault;
          res.saved_interrupted = ent_ipc;
          res.saved_resume      = ent_rpc;
        end
      end

      // Exception return
      if (cmd_i.kind.is_return) begin
        if (!active_q) begin
          res.status = etiu_pkg::ST_NO_ACTIVE;
        end else if (!cmd_i.tgt_aligned) begin
          res.status = etiu_pkg::ST_MISALIGNED;
        end else if (!cmd_i.target_usable) begin
          res.status = etiu_pkg::ST_NOT_EXEC;
        end else begin
          active_d           = 1'b0;
          irq_en_d           = 1'b1;
          res.returned       = 1'b1;
          res.next_pc        = cmd_i.return_target;
          res.restored_flags = ctx_flags_q;
        end
      end

      if (cmd_i.kind.is_set_en) begin
        irq_en_d = cmd_i.enable_value;
      end

      if (cmd_i.kind.is_queue) begin
        pending_d = 1'b1;
      end
    end

    // Period write re-arms the deadline, or clears it for a zero period
    if (cfg_wr_i.period_wr) begin
      pending_d = 1'b0;
      rearm_d   = !cfg_wr_i.period_zero;
      if (cfg_wr_i.period_zero) begin
        deadline_d = '0;
      end
    end

    res.handler_active = active_d;
    res.irq_enabled    = irq_en_d;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      irq_en_q    <= 1'b0;
      pending_q   <= 1'b0;
      rearm_q     <= 1'b0;
      deadline_q  <= '0;
      ctx_flags_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      irq_en_q    <= irq_en_d;
      pending_q   <= pending_d;
      rearm_q     <= rearm_d;
      deadline_q  <= deadline_d;
      ctx_flags_q <= ctx_flags_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `ETIU_ASSERT_NEVER(a_enter_and_return, out_valid_q && out_word_q.entered && out_word_q.returned, "entry and return on one word")
  `ETIU_ASSERT(a_enter_active, fire && res.entered |=> active_q && !irq_en_q, "entry left handler inactive")
  `ETIU_ASSERT(a_return_state, fire && res.returned |=> !active_q && irq_en_q, "return left handler active")

endmodule

`default_nettype wire

// ----- dv/exception_and_timer_interrupt_unit_tb.sv -----
// Testbench for the exception and timer interrupt unit: directed table, random sequences, checks.
module exception_and_timer_interrupt_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Operation codes the unit ignores
  localparam logic [2:0] OP_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] OP_UNKNOWN_HI = 3'd7;

  localparam logic [63:0] ALL_ONES = '1;
  localparam logic [63:0] VEC_TOP = 64'hFFFF_FFFF_FFFF_FFFC;
  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned WORDS_PER_PHASE = 235;

  // One step of the directed table: a register write or an input word
  typedef struct {
    bit                  is_cfg;
    logic [1:0]          reg_idx;
    logic [63:0]         value;
    etiu_pkg::in_word_t  w;
    bit                  typed;
    etiu_pkg::out_word_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid_q = 1'b0;
  etiu_pkg::in_word_t in_word_q = '0;
  logic in_stall;
  logic out_valid;
  logic out_stall_q = 1'b0;
  etiu_pkg::out_word_t out_word;

  logic psel_q = 1'b0;
  logic penable_q = 1'b0;
  logic pwrite_q = 1'b0;
  logic [etiu_pkg::CFG_ADDR_W-1:0] paddr_q = '0;
  logic [63:0] pwdata_q = '0;
  logic [63:0] prdata;
  logic pready;

  // Shadow of the unit's registers and state
  logic [63:0] m_vec_base;
  logic        m_vec_valid;
  logic [63:0] m_period;
  logic [63:0] m_deadline;
  logic        m_rearm;
  logic        m_active;
  logic        m_irq_en;
  logic        m_pending;
  logic [3:0]  m_ctx_flags;

  etiu_pkg::out_word_t outcome_q[$];
  etiu_pkg::out_word_t want_w;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned burst_left;
  logic [63:0] retire_ct;

  exception_and_timer_interrupt_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_q),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word_q),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall_q),
    .out_word_o  (out_word),
    .psel        (psel_q),
    .penable     (penable_q),
    .pwrite      (pwrite_q),
    .paddr       (paddr_q),
    .pwdata      (pwdata_q),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Handler entry: vector configured, not nested, vector aligned and usable
  function automatic logic [2:0] enter_handler(logic [3:0] cause, logic [63:0] fault,
                                               logic [63:0] ipc, logic [63:0] rpc,
                                               logic [3:0] flags, logic usable,
                                               inout etiu_pkg::out_word_t r);
    if (!m_vec_valid) return etiu_pkg::ST_UNHANDLED;
    if (m_active) return etiu_pkg::ST_NESTED;
    if ((m_vec_base[1:0] & etiu_pkg::ALIGN_MASK) != '0 || !usable) begin
      return etiu_pkg::ST_BAD_VECTOR;
    end
    m_active = 1'b1;
    m_irq_en = 1'b0;
    m_ctx_flags = flags;
    r.entered = 1'b1;
    r.next_pc = m_vec_base;
    r.saved_cause = cause;
    r.saved_fault = fault;
    r.saved_interrupted = ipc;
    r.saved_resume = rpc;
    return etiu_pkg::ST_OK;
  endfunction

  // Expected result word for one accepted input word; advances the shadow state
  function automatic etiu_pkg::out_word_t predict_outcome(etiu_pkg::in_word_t w);
    etiu_pkg::out_word_t r;
    r = '0;
    case (w.operation)
      etiu_pkg::OP_TICK: begin
        // deadline first, then sample the pending timer interrupt
        if (m_period != '0 && !m_active) begin
          if (m_rearm) begin
            m_deadline = w.retired_count + m_period;
            m_rearm = 1'b0;
          end
          if (w.retired_count >= m_deadline) begin
            m_pending = 1'b1;
            m_deadline = m_deadline + m_period;
          end
        end
        if (m_irq_en && !m_active && m_pending) begin
          m_pending = 1'b0;
          r.status = enter_handler(etiu_pkg::TIMER_CAUSE, '0, w.current_pc, w.current_pc,
                                   w.cpu_flags, w.target_usable, r);
        end
      end
      etiu_pkg::OP_RAISE: begin
        r.status = enter_handler(w.cause_code, w.fault_addr, w.current_pc, w.resume_addr,
                                 w.cpu_flags, w.target_usable, r);
      end
      etiu_pkg::OP_RETURN: begin
        if (!m_active) r.status = etiu_pkg::ST_NO_ACTIVE;
        else if ((w.return_target[1:0] & etiu_pkg::ALIGN_MASK) != '0) begin
          r.status = etiu_pkg::ST_MISALIGNED;
        end
        else if (!w.target_usable) r.status = etiu_pkg::ST_NOT_EXEC;
        else begin
          m_active = 1'b0;
          m_irq_en = 1'b1;
          r.returned = 1'b1;
          r.next_pc = w.return_target;
          r.restored_flags = m_ctx_flags;
        end
      end
      etiu_pkg::OP_SET_EN: m_irq_en = w.enable_value;
      etiu_pkg::OP_QUEUE_IRQ: m_pending = 1'b1;
      default: ;
    endcase
    r.handler_active = m_active;
    r.irq_enabled = m_irq_en;
    return r;
  endfunction

  function automatic etiu_pkg::in_word_t mk_word(logic [2:0] op, logic [3:0] cause,
                                                 logic [63:0] fault, logic [63:0] pc,
                                                 logic [63:0] resume, logic [63:0] target,
                                                 logic [3:0] flags, logic [63:0] retired,
                                                 logic usable, logic en);
    etiu_pkg::in_word_t w;
    w.operation = op;
    w.cause_code = cause;
    w.fault_addr = fault;
    w.current_pc = pc;
    w.resume_addr = resume;
    w.return_target = target;
    w.cpu_flags = flags;
    w.retired_count = retired;
    w.target_usable = usable;
    w.enable_value = en;
    return w;
  endfunction

  function automatic etiu_pkg::out_word_t mk_result(logic [2:0] st, logic ent, logic ret,
                                                    logic [63:0] pc, logic [3:0] cause,
                                                    logic [63:0] fault, logic [63:0] intr,
                                                    logic [63:0] resume, logic [3:0] flags,
                                                    logic act, logic irq);
    etiu_pkg::out_word_t r;
    r.status = st;
    r.entered = ent;
    r.returned = ret;
    r.next_pc = pc;
    r.saved_cause = cause;
    r.saved_fault = fault;
    r.saved_interrupted = intr;
    r.saved_resume = resume;
    r.restored_flags = flags;
    r.handler_active = act;
    r.irq_enabled = irq;
    return r;
  endfunction

  function automatic row_t item_row(etiu_pkg::in_word_t w);
    row_t r;
    r = '{default: '0};
    r.w = w;
    return r;
  endfunction

  function automatic row_t typed_row(etiu_pkg::in_word_t w, etiu_pkg::out_word_t want);
    row_t r;
    r = item_row(w);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [1:0] idx, logic [63:0] value);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.value = value;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic etiu_pkg::in_word_t rand_word();
    return mk_word(3'($urandom_range(7)), 4'($urandom), rand64(), rand64(), rand64(),
                   rand64(), 4'($urandom), rand64(), 1'($urandom), 1'($urandom));
  endfunction

  // Tick with the retire count moving forward by a few instructions
  function automatic etiu_pkg::in_word_t tick_word();
    etiu_pkg::in_word_t w;
    w = rand_word();
    w.operation = etiu_pkg::OP_TICK;
    retire_ct = retire_ct + 64'($urandom_range(1, 3));
    w.retired_count = retire_ct;
    w.target_usable = ($urandom_range(19) != 0);
    return w;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // APB write: setup phase, then access phase, then idle; shadow follows
  task automatic cfg_write(logic [1:0] idx, logic [63:0] value);
    psel_q <= 1'b1;
    pwrite_q <= 1'b1;
    penable_q <= 1'b0;
    paddr_q <= {idx, 3'b000};
    pwdata_q <= value;
    @(posedge clk_i);
    penable_q <= 1'b1;
    @(posedge clk_i);
    psel_q <= 1'b0;
    penable_q <= 1'b0;
    pwrite_q <= 1'b0;
    @(posedge clk_i);
    case (idx)
      etiu_pkg::REG_VEC_ADDR: m_vec_base = value;
      etiu_pkg::REG_VECTOR_VALID: m_vec_valid = value[0];
      etiu_pkg::REG_TIMER_PERIOD: begin
        m_period = value;
        m_pending = 1'b0;
        m_rearm = (value != '0);
        if (value == '0) m_deadline = '0;
      end
      default: ;
    endcase
  endtask

  // Wait until every predicted word has come back, then let the pipe settle
  task automatic drain();
    in_valid_q <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Offer one word until accepted, then pace the next one in bursts
  task automatic send_word(etiu_pkg::in_word_t w, bit typed, etiu_pkg::out_word_t want);
    etiu_pkg::out_word_t predicted;
    int unsigned gap;
    in_valid_q <= 1'b1;
    in_word_q <= w;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    predicted = predict_outcome(w);
    outcome_q.push_back(typed ? want : predicted);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_q <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Random traffic: mostly raise/tick/return sequences, some noise
  task automatic run_random(int unsigned n);
    int unsigned start;
    int unsigned pick;
    int unsigned k;
    etiu_pkg::in_word_t w;
    start = words_sent;
    while (words_sent - start < n) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        k = $urandom_range(1, 8);
        repeat (k) send_word(tick_word(), 1'b0, '0);
      end else if (pick < 52) begin
        w = rand_word();
        w.operation = etiu_pkg::OP_RAISE;
        w.target_usable = ($urandom_range(9) != 0);
        send_word(w, 1'b0, '0);
        k = $urandom_range(0, 4);
        repeat (k) send_word(tick_word(), 1'b0, '0);
        w = rand_word();
        w.operation = etiu_pkg::OP_RETURN;
        if ($urandom_range(3) != 0) begin
          w.return_target[1:0] = 2'b00;
          w.target_usable = 1'b1;
        end
        if ($urandom_range(7) != 0) send_word(w, 1'b0, '0);
      end else if (pick < 60) begin
        w = rand_word();
        w.operation = etiu_pkg::OP_RETURN;
        send_word(w, 1'b0, '0);
      end else if (pick < 70) begin
        w = rand_word();
        w.operation = etiu_pkg::OP_SET_EN;
        w.enable_value = ($urandom_range(4) != 0);
        send_word(w, 1'b0, '0);
      end else if (pick < 78) begin
        w = rand_word();
        w.operation = etiu_pkg::OP_QUEUE_IRQ;
        send_word(w, 1'b0, '0);
        send_word(tick_word(), 1'b0, '0);
      end else begin
        // noise; now and then the retire count jumps anywhere
        w = rand_word();
        if ($urandom_range(7) != 0) w.retired_count = retire_ct;
        else retire_ct = w.retired_count;
        send_word(w, 1'b0, '0);
      end
    end
  endtask

  // Stimulus: reset, directed table, random phases, end of run
  initial begin
    row_t dir_rows[$];
    logic [63:0] base;
    logic [63:0] period;
    logic valid;
    m_vec_base = '0;
    m_vec_valid = 1'b0;
    m_period = '0;
    m_deadline = '0;
    m_rearm = 1'b0;
    m_active = 1'b0;
    m_irq_en = 1'b0;
    m_pending = 1'b0;
    m_ctx_flags = '0;
    words_sent = 0;
    burst_left = 0;
    retire_ct = '0;

    // reset state, no vector, timer off
    dir_rows.push_back(typed_row(
        mk_word(etiu_pkg::OP_TICK, '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0),
        mk_result(etiu_pkg::ST_OK, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0)));
    dir_rows.push_back(typed_row(
        mk_word(etiu_pkg::OP_RAISE, '1, ALL_ONES, ALL_ONES, ALL_ONES, '0, '1, '0, 1'b1, 1'b0),
        mk_result(etiu_pkg::ST_UNHANDLED, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0)));
    dir_rows.push_back(typed_row(
        mk_word(etiu_pkg::OP_RETURN, '0, '0, '0, '0, '0, '0, '0, 1'b1, 1'b0),
        mk_result(etiu_pkg::ST_NO_ACTIVE, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0)));
    dir_rows.push_back(typed_row(
        mk_word(OP_UNKNOWN_HI, '1, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, '1, ALL_ONES,
                1'b1, 1'b1),
        mk_result(etiu_pkg::ST_OK, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0)));
    dir_rows.push_back(typed_row(
        mk_word(OP_UNKNOWN_LO, '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1),
        mk_result(etiu_pkg::ST_OK, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0)));
    dir_rows.push_back(typed_row(
        mk_word(etiu_pkg::OP_SET_EN, '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1),
        mk_result(etiu_pkg::ST_OK, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1)));
    dir_rows.push_back(typed_row(
        mk_word(etiu_pkg::OP_QUEUE_IRQ, '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0),
        mk_result(etiu_pkg::ST_OK, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1)));
    // pending timer interrupt with no vector: dropped as unhandled
    dir_rows.push_back(typed_row(
        mk_word(etiu_pkg::OP_TICK, '0, '0, 64'h40, '0, '0, '0, '0, 1'b1, 1'b0),
        mk_result(etiu_pkg::ST_UNHANDLED, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1)));
    dir_rows.push_back(cfg_row(etiu_pkg::REG_VEC_ADDR, VEC_TOP));
    dir_rows.push_back(cfg_row(etiu_pkg::REG_VECTOR_VALID, 64'd1));
    // entry with all-ones context, then the failure paths and a good return
    dir_rows.push_back(typed_row(
        mk_word(etiu_pkg::OP_RAISE, '1, ALL_ONES, ALL_ONES, ALL_ONES, '0, '1, '0, 1'b1, 1'b0),
        mk_result(etiu_pkg::ST_OK, 1'b1, 1'b0, VEC_TOP, '1, ALL_ONES, ALL_ONES, ALL_ONES,
                  '0, 1'b1, 1'b0)));
    dir_rows.push_back(typed_row(
        mk_word(etiu_pkg::OP_RAISE, '0, '0, '0, '0, '0, '0, '0, 1'b1, 1'b0),
        mk_result(etiu_pkg::ST_NESTED, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0, 1'b1, 1'b0)));
    dir_rows.push_back(typed_row(
        mk_word(etiu_pkg::OP_RETURN, '0, '0, '0, '0, 64'h2, '0, '0, 1'b1, 1'b0),
        mk_result(etiu_pkg::ST_MISALIGNED, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0, 1'b1, 1'b0)));
    dir_rows.push_back(typed_row(
        mk_word(etiu_pkg::OP_RETURN, '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0),
        mk_result(etiu_pkg::ST_NOT_EXEC, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0, 1'b1, 1'b0)));
    dir_rows.push_back(typed_row(
        mk_word(etiu_pkg::OP_RETURN, '0, '0, '0, '0, VEC_TOP, '0, '0, 1'b1, 1'b0),
        mk_result(etiu_pkg::ST_OK, 1'b0, 1'b1, VEC_TOP, '0, '0, '0, '0, '1, 1'b0, 1'b1)));
    dir_rows.push_back(typed_row(
        mk_word(etiu_pkg::OP_RAISE, 4'd3, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0),
        mk_result(etiu_pkg::ST_BAD_VECTOR, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1)));
    dir_rows.push_back(cfg_row(etiu_pkg::REG_VEC_ADDR, 64'h1));
    dir_rows.push_back(typed_row(
        mk_word(etiu_pkg::OP_RAISE, 4'd3, '0, '0, '0, '0, '0, '0, 1'b1, 1'b0),
        mk_result(etiu_pkg::ST_BAD_VECTOR, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1)));
    // timer: rearm, fire, hold while active
    dir_rows.push_back(cfg_row(etiu_pkg::REG_VEC_ADDR, 64'h1000));
    dir_rows.push_back(cfg_row(etiu_pkg::REG_TIMER_PERIOD, 64'd3));
    dir_rows.push_back(item_row(mk_word(etiu_pkg::OP_TICK, '0, '0, 64'h200, '0, '0, 4'h5,
                                        64'd100, 1'b1, 1'b0)));
    dir_rows.push_back(item_row(mk_word(etiu_pkg::OP_TICK, '0, '0, 64'h204, '0, '0, 4'ha,
                                        64'd103, 1'b1, 1'b0)));
    dir_rows.push_back(item_row(mk_word(etiu_pkg::OP_TICK, '0, '0, 64'h208, '0, '0, '0,
                                        64'd200, 1'b1, 1'b0)));
    dir_rows.push_back(item_row(mk_word(etiu_pkg::OP_RETURN, '0, '0, '0, '0, 64'h204, '0,
                                        '0, 1'b1, 1'b0)));
    // deadline wraps past 2^64
    dir_rows.push_back(cfg_row(etiu_pkg::REG_TIMER_PERIOD, ALL_ONES));
    dir_rows.push_back(item_row(mk_word(etiu_pkg::OP_TICK, '0, '0, 64'h300, '0, '0, 4'h9,
                                        64'd5, 1'b1, 1'b0)));
    dir_rows.push_back(item_row(mk_word(etiu_pkg::OP_RETURN, '0, '0, '0, '0, 64'h300, '0,
                                        '0, 1'b1, 1'b0)));
    // pending interrupt held back while the enable is off
    dir_rows.push_back(item_row(mk_word(etiu_pkg::OP_SET_EN, '0, '0, '0, '0, '0, '0, '0,
                                        1'b0, 1'b0)));
    dir_rows.push_back(item_row(mk_word(etiu_pkg::OP_QUEUE_IRQ, '0, '0, '0, '0, '0, '0, '0,
                                        1'b0, 1'b0)));
    dir_rows.push_back(item_row(mk_word(etiu_pkg::OP_TICK, '0, '0, 64'h304, '0, '0, '0,
                                        64'd6, 1'b1, 1'b0)));
    // cause above the timer cause is kept as given
    dir_rows.push_back(cfg_row(etiu_pkg::REG_TIMER_PERIOD, '0));
    dir_rows.push_back(item_row(mk_word(etiu_pkg::OP_RAISE, 4'd13, 64'hdead, 64'h400,
                                        64'h404, '0, 4'h3, '0, 1'b1, 1'b0)));
    dir_rows.push_back(item_row(mk_word(etiu_pkg::OP_RETURN, '0, '0, '0, '0, 64'h404, '0,
                                        '0, 1'b1, 1'b0)));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain();
        cfg_write(dir_rows[i].reg_idx, dir_rows[i].value);
      end else begin
        send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      base = rand64() & ~64'h3;
      valid = 1'b1;
      case (ph)
        0: period = 64'd5;
        1: begin
          base = ALL_ONES;
          period = 64'd1;
        end
        2: begin
          base = VEC_TOP;
          period = '0;
        end
        3: begin
          valid = 1'b0;
          period = 64'd17;
        end
        4: period = ALL_ONES;
        5: begin
          base = '0;
          period = 64'($urandom_range(1, 40));
        end
        6: begin
          base = rand64();
          period = 64'($urandom_range(1, 8));
        end
        default: period = 64'd3;
      endcase
      cfg_write(etiu_pkg::REG_VEC_ADDR, base);
      cfg_write(etiu_pkg::REG_VECTOR_VALID, {63'd0, valid});
      cfg_write(etiu_pkg::REG_TIMER_PERIOD, period);
      retire_ct = rand64() >> $urandom_range(0, 63);
      run_random(WORDS_PER_PHASE);
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** exception_and_timer_interrupt_unit: PASSED **");
    end else begin
      $display("** exception_and_timer_interrupt_unit: FAILED **");
    end
    $finish;
  end

  // Receiver stall pattern: segments of random density, plus two long hold-offs
  initial begin : receiver
    int unsigned seg_left;
    int unsigned stall_pct;
    int unsigned hold_left;
    int unsigned holds_done;
    seg_left = 0;
    stall_pct = 0;
    hold_left = 0;
    holds_done = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 200);
        case ($urandom_range(4))
          0, 1: stall_pct = 0;
          2: stall_pct = 30;
          3: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      seg_left--;
      if (hold_left == 0 && holds_done < 2 && words_checked >= 400 + 800 * holds_done) begin
        hold_left = 150;
        holds_done++;
      end
      if (hold_left != 0) begin
        out_stall_q <= 1'b1;
        hold_left--;
      end else begin
        out_stall_q <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Result check against the oldest predicted word
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall_q) begin
      words_checked++;
      if (outcome_q.size() == 0) begin
        $error("result word with no prediction waiting");
        mismatches++;
      end else begin
        want_w = outcome_q.pop_front();
        check_field("status", 64'(want_w.status), 64'(out_word.status));
        check_field("entered", 64'(want_w.entered), 64'(out_word.entered));
        check_field("returned", 64'(want_w.returned), 64'(out_word.returned));
        check_field("next_pc", want_w.next_pc, out_word.next_pc);
        check_field("saved_cause", 64'(want_w.saved_cause), 64'(out_word.saved_cause));
        check_field("saved_fault", want_w.saved_fault, out_word.saved_fault);
        check_field("saved_interrupted", want_w.saved_interrupted,
                    out_word.saved_interrupted);
        check_field("saved_resume", want_w.saved_resume, out_word.saved_resume);
        check_field("restored_flags", 64'(want_w.restored_flags),
                    64'(out_word.restored_flags));
        check_field("handler_active", 64'(want_w.handler_active),
                    64'(out_word.handler_active));
        check_field("irq_enabled", 64'(want_w.irq_enabled), 64'(out_word.irq_enabled));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** exception_and_timer_interrupt_unit: FAILED **");
      $finish;
    end
  end

endmodule
